// ===== hdl/smpq_pkg.sv =====
// Package for the sorted minimum priority queue: default sizes, command codes, word types, states.
package smpq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] top_key;
        logic               is_empty;
        logic [4:0]         entry_count;
        logic               overflow;
    } result_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHECK,
        ST_INS_CMP,
        ST_POP_RD,
        ST_POP_WR,
        ST_TOP_RD,
        ST_TOP_CAP
    } state_t;

endpackage

// ===== hdl/sorted_min_priority_queue.sv =====
// Sorted minimum priority queue: command sequencer with one shared key compare over a key store.
// Push moves each stored key greater than the new key up one slot, from the back, then writes the new key;
// a full queue only flags overflow. Pop shifts the remaining keys down one slot; clear zeroes the count.
// Every command, also an unused code, ends by reporting front key (zero when empty), count and overflow.
// Throughput: one command at a time; busy falls as done rises, so the next word may start then.
// Reset clears the entry count and sequencer, not the key store; the receiver cannot stall.
module sorted_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  cmd_word_t    item,
    output logic         busy,
    output logic         done,
    output result_word_t result
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 ovf_reg, ovf_next;
    logic                 done_reg, done_next;
    result_word_t         result_reg, result_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;

    logic [KEY_WIDTH+31:0] key_ext;
    logic [KEY_WIDTH-1:0]  key_in;
    logic [CNT_W-1:0]      idx_dec;
    logic                  key_less;
    logic [KEY_WIDTH-1:0]  top_val;
    logic [KEY_WIDTH+31:0] top_ext;
    logic [CNT_W+4:0]      cnt_ext;

    assign key_ext  = {{KEY_WIDTH{1'b0}}, item.key};
    assign key_in   = key_ext[KEY_WIDTH-1:0];
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign key_less = $signed(key_reg) < $signed(rd_data);
    assign top_ext  = {32'b0, top_val};
    assign cnt_ext  = {5'b0, count_reg};

    smpq_key_ram #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        ovf_next    = ovf_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = key_reg;
        rd_addr     = idx_dec[AW-1:0];
        top_val     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ovf_next   = 1'b0;
                    state_next = ST_TOP_RD;
                    unique case (item.command)
                        CMD_PUSH:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                key_next   = key_in;
                                state_next = ST_INS_CHECK;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                idx_next   = CNT_W'(1);
                                state_next = ST_POP_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_TOP_RD;
                        end
                    endcase
                end
            end
            ST_INS_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_TOP_RD;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (key_less)
                begin
                    wr_data    = rd_data;
                    idx_next   = idx_dec;
                    state_next = ST_INS_CHECK;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_TOP_RD;
                end
            end
            ST_POP_RD:
            begin
                rd_addr = idx_reg[AW-1:0];
                if (idx_reg >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_TOP_RD;
                end
                else
                begin
                    state_next = ST_POP_WR;
                end
            end
            ST_POP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_dec[AW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_POP_RD;
            end
            ST_TOP_RD:
            begin
                rd_addr = '0;
                if (count_reg == '0)
                begin
                    result_next.top_key     = top_ext[31:0];
                    result_next.is_empty    = 1'b1;
                    result_next.entry_count = cnt_ext[4:0];
                    result_next.overflow    = ovf_reg;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    state_next = ST_TOP_CAP;
                end
            end
            ST_TOP_CAP:
            begin
                top_val                 = rd_data;
                result_next.top_key     = top_ext[31:0];
                result_next.is_empty    = 1'b0;
                result_next.entry_count = cnt_ext[4:0];
                result_next.overflow    = ovf_reg;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while sequencer busy");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("overflow reported with room left");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.top_key == '0 && count_reg == '0))
        else $error("empty result with stale key or count");

endmodule

// ===== hdl/smpq_key_ram.sv =====
// Key store: one write port and one registered read port.
module smpq_key_ram
    import smpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [KEY_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [KEY_WIDTH-1:0] rd_data
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/sv/sorted_min_priority_queue_test.sv =====
// Testbench for the sorted minimum priority queue: random and directed commands, scoreboard check.
`timescale 1ns / 100ps

module sorted_min_priority_queue_test;
    import smpq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WORD_TOTAL = 1250;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    class sorted_queue_checker;
        logic signed [31:0] model_keys[$];
        result_word_t       awaited_reports[$];
        int                 mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function int pending();
            return awaited_reports.size();
        endfunction

        function void note_command(input cmd_word_t w);
            result_word_t       r;
            logic signed [31:0] k;
            int                 pos;
            r = '0;
            k = $signed(w.key);
            case (w.command)
                CMD_PUSH:
                begin
                    if (model_keys.size() >= CAPACITY_DEF)
                    begin
                        r.overflow = 1'b1;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < model_keys.size() && model_keys[pos] <= k)
                            pos++;
                        model_keys.insert(pos, k);
                    end
                end
                CMD_POP:
                begin
                    if (model_keys.size() > 0)
                        void'(model_keys.pop_front());
                end
                CMD_CLEAR:
                begin
                    model_keys.delete();
                end
                default:
                begin
                end
            endcase
            r.top_key     = (model_keys.size() > 0) ? model_keys[0] : '0;
            r.is_empty    = (model_keys.size() == 0);
            r.entry_count = 5'(model_keys.size());
            awaited_reports.push_back(r);
        endfunction

        task check_result(input result_word_t got);
            result_word_t want;
            if (awaited_reports.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing awaited", got));
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (got.top_key !== want.top_key)
                    report_mismatch($sformatf("top_key %h, want %h", got.top_key, want.top_key));
                if (got.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty %b, want %b", got.is_empty,
                                              want.is_empty));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, want %0d", got.entry_count,
                                              want.entry_count));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b", got.overflow,
                                              want.overflow));
            end
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         start;
    cmd_word_t    item;
    logic         busy;
    logic         done;
    result_word_t result;

    sorted_queue_checker sb;

    sorted_min_priority_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("sorted_min_priority_queue_test: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic cmd_word_t make_word(input logic [1:0] cmd, input logic [31:0] k);
        cmd_word_t w;
        w.command = cmd;
        w.key     = k;
        return w;
    endfunction

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 32'($signed($urandom_range(7)) - 3) <<< 16;
        else if (r < 50)
            return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_command(input traffic_mode_t mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:
            begin
                if (r < 82) return CMD_PUSH;
                if (r < 95) return CMD_POP;
                if (r < 99) return CMD_UNUSED;
                return CMD_CLEAR;
            end
            MODE_DRAIN:
            begin
                if (r < 25) return CMD_PUSH;
                if (r < 92) return CMD_POP;
                if (r < 97) return CMD_UNUSED;
                return CMD_CLEAR;
            end
            default:
            begin
                if (r < 50) return CMD_PUSH;
                if (r < 88) return CMD_POP;
                if (r < 95) return CMD_UNUSED;
                return CMD_CLEAR;
            end
        endcase
    endfunction

    task automatic issue_command(input cmd_word_t w);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(w);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        cmd_word_t     directed[$];
        traffic_mode_t mode;
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        mode  = MODE_FILL;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_word(CMD_POP, 32'h1234_5678));
        directed.push_back(make_word(CMD_UNUSED, 32'hffff_ffff));
        directed.push_back(make_word(CMD_PUSH, 32'h7fff_ffff));
        directed.push_back(make_word(CMD_PUSH, 32'h8000_0000));
        directed.push_back(make_word(CMD_PUSH, 32'h8000_0000));
        directed.push_back(make_word(CMD_PUSH, 32'h7fff_ffff));
        directed.push_back(make_word(CMD_PUSH, 32'h0000_0000));
        directed.push_back(make_word(CMD_PUSH, 32'h0000_0000));
        directed.push_back(make_word(CMD_PUSH, 32'hffff_ffff));
        directed.push_back(make_word(CMD_PUSH, 32'h0001_0000));
        directed.push_back(make_word(CMD_POP, 32'h0));
        directed.push_back(make_word(CMD_POP, 32'h0));
        directed.push_back(make_word(CMD_UNUSED, 32'h0));
        directed.push_back(make_word(CMD_CLEAR, 32'hffff_ffff));
        directed.push_back(make_word(CMD_POP, 32'h0));
        directed.push_back(make_word(CMD_CLEAR, 32'h0));
        directed.push_back(make_word(CMD_PUSH, 32'h8000_0001));
        foreach (directed[i])
            issue_command(directed[i]);
        drain_results();

        for (int n = 0; n < WORD_TOTAL; n++)
        begin
            if (n % 40 == 0)
                mode = traffic_mode_t'($urandom_range(2));
            issue_command(make_word(pick_command(mode), pick_key()));
            if (n == 640 || n == 1000)
                drain_results();
            else if (!(n >= 300 && n < 500) && $urandom_range(99) < 25)
                pause_sender($urandom_range(1, 30));
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("sorted_min_priority_queue_test: clean");
        else
            $display("sorted_min_priority_queue_test: errors");
        $finish;
    end

endmodule
